[design/vdc_pkg.sv]
// Shared types, constants and helper functions of the video controller register port.
// Used by the front, back and top-level modules; no dependencies.
package vdc_pkg;

  localparam int VRAM_DEPTH = 65536;
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int REG_COUNT  = 38;
  localparam int REG_DEPTH  = 64;
  localparam int REG_AW     = $clog2(REG_DEPTH);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [1:0] CMD_PORT_RD = 2'd0;
  localparam logic [1:0] CMD_PORT_WR = 2'd1;
  localparam logic [1:0] CMD_RAM_RD  = 2'd2;
  localparam logic [1:0] CMD_RAM_WR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RAM_64K  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_REV = 1'd1;

  localparam logic [REG_AW-1:0] REG_UPD_HI   = 6'd18;
  localparam logic [REG_AW-1:0] REG_UPD_LO   = 6'd19;
  localparam logic [REG_AW-1:0] REG_BLK_MODE = 6'd24;
  localparam logic [REG_AW-1:0] REG_RAM_CFG  = 6'd28;
  localparam logic [REG_AW-1:0] REG_WORD_CNT = 6'd30;
  localparam logic [REG_AW-1:0] REG_DATA     = 6'd31;
  localparam logic [REG_AW-1:0] REG_SRC_HI   = 6'd32;
  localparam logic [REG_AW-1:0] REG_SRC_LO   = 6'd33;

  typedef enum logic [2:0] {
    KIND_STATUS,
    KIND_SELECT,
    KIND_REG_RD,
    KIND_REG_WR,
    KIND_RAM_RD,
    KIND_RAM_WR
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        vblank;
  } entry_t;

  // Bits of each register that are not implemented and read back as one.
  function automatic logic [7:0] unused_bits(logic [REG_AW-1:0] idx);
    logic [7:0] v;
    case (idx)
      6'd5, 6'd9, 6'd11, 6'd23, 6'd29: v = 8'hE0;
      6'd8:    v = 8'hFC;
      6'd10:   v = 8'h80;
      6'd36:   v = 8'hF0;
      6'd37:   v = 8'h3F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [VRAM_AW-1:0] mask_addr(logic [15:0] a, logic ram_64k);
    logic [15:0] m;
    m = ram_64k ? a : {2'b00, a[13:0]};
    return m[VRAM_AW-1:0];
  endfunction

endpackage

[design/video_controller_indirect_register_port.sv]
// Indirect register port of the video controller: a two-entry command queue
// feeds an executor that owns the register file and the video RAM. Results are
// presented for one cycle with read_valid_o and cannot be held off by the
// receiver. Commands are accepted whenever busy_o is low, that is while the
// queue has a free slot. Once the executor picks up a command, a status read,
// a register select and most writes finish in the execute state, while a read
// of a plain register or of video RAM passes through an output state; the
// result is registered and appears in the cycle after the state that makes it.
// A write to the word count register starts a block fill or copy of up to 256
// bytes that holds the executor; a copy reads and writes each byte in turn.
// The user must write configuration through cfg_we_i, cfg_idx_i and cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// Depends on vdc_pkg, vdc_front and vdc_back.
module video_controller_indirect_register_port (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     cmd_i,
  input  logic [15:0]                    addr_i,
  input  logic [7:0]                     data_i,
  input  logic                           in_vblank_i,
  output logic                           read_valid_o,
  output logic [7:0]                     read_data_o,
  input  logic                           cfg_we_i,
  input  logic [vdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vdc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import vdc_pkg::*;

  logic       ram_64k_q;
  logic [2:0] chip_rev_q;
  logic       q_valid;
  logic       pop;
  entry_t     entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_64k_q  <= 1'b1;
      chip_rev_q <= 3'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RAM_64K:  ram_64k_q  <= cfg_wdata_i[0];
        CFG_CHIP_REV: chip_rev_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  vdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .addr_i      (addr_i),
    .data_i      (data_i),
    .in_vblank_i (in_vblank_i),
    .busy_o      (busy_o),
    .q_valid_o   (q_valid),
    .entry_o     (entry),
    .pop_i       (pop)
  );

  vdc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .entry_i      (entry),
    .pop_o        (pop),
    .ram_64k_i    (ram_64k_q),
    .chip_rev_i   (chip_rev_q),
    .read_valid_o (read_valid_o),
    .read_data_o  (read_data_o)
  );

  // The executor never takes a command from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("command popped from an empty queue");

  // A full queue always offers a command to the executor.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |-> q_valid)
    else $error("queue reports full but holds no command");

  // After every result the executor returns to its idle state to fetch the next
  // command, so results are never presented in two consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni) read_valid_o |=> !read_valid_o)
    else $error("results presented in back-to-back cycles");

  // A command is taken only while the executor has finished its output.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> !read_valid_o)
    else $error("result presented right after a command was taken");

endmodule

[design/vdc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined after reset.
module vdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/vdc_front.sv]
// Front end: accepts host commands, classifies them and queues them for the back end.
// Depends on vdc_pkg.
module vdc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      cmd_i,
  input  logic [15:0]     addr_i,
  input  logic [7:0]      data_i,
  input  logic            in_vblank_i,
  output logic            busy_o,
  output logic            q_valid_o,
  output vdc_pkg::entry_t entry_o,
  input  logic            pop_i
);
  import vdc_pkg::*;

  entry_t     slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  entry_t     new_entry;

  always_comb begin
    new_entry.addr   = addr_i;
    new_entry.data   = data_i;
    new_entry.vblank = in_vblank_i;
    case (cmd_i)
      CMD_PORT_RD: new_entry.kind = addr_i[0] ? KIND_REG_RD : KIND_STATUS;
      CMD_PORT_WR: new_entry.kind = addr_i[0] ? KIND_REG_WR : KIND_SELECT;
      CMD_RAM_RD:  new_entry.kind = KIND_RAM_RD;
      default:     new_entry.kind = KIND_RAM_WR;
    endcase
  end

  assign busy_o    = (count_q == 2'd2);
  assign q_valid_o = (count_q != 2'd0);
  assign push      = start_i && !busy_o;
  assign entry_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[design/vdc_back.sv]
// Back end: executes queued commands against the register file and video RAM,
// including block fill and copy. Depends on vdc_pkg and vdc_ram.
module vdc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  vdc_pkg::entry_t entry_i,
  output logic            pop_o,
  input  logic            ram_64k_i,
  input  logic [2:0]      chip_rev_i,
  output logic            read_valid_o,
  output logic [7:0]      read_data_o
);
  import vdc_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_EXEC     = 3'd1;
  localparam logic [2:0] ST_REG_OUT  = 3'd2;
  localparam logic [2:0] ST_VRAM_OUT = 3'd3;
  localparam logic [2:0] ST_FILL     = 3'd4;
  localparam logic [2:0] ST_BLK_RD   = 3'd5;
  localparam logic [2:0] ST_BLK_WR   = 3'd6;

  localparam logic [REG_AW:0] RegCountV = (REG_AW+1)'(REG_COUNT);

  logic [2:0]        state_q, state_d;
  entry_t            cur_q;
  logic [REG_AW-1:0] sel_q, sel_d;
  logic [15:0]       upd_q, upd_d;
  logic [15:0]       src_q, src_d;
  logic [7:0]        r24_q, r24_d;
  logic [7:0]        r28_q, r28_d;
  logic [7:0]        r30_q, r30_d;
  logic [7:0]        r31_q, r31_d;
  logic [8:0]        cnt_q, cnt_d;
  logic [8:0]        len_q, len_d;
  logic [REG_DEPTH-1:0] valid_q, valid_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;

  logic               vram_we;
  logic [VRAM_AW-1:0] vram_waddr, vram_raddr;
  logic [7:0]         vram_wdata, vram_rdata;
  logic               reg_we;
  logic [7:0]         reg_rdata;

  logic [15:0] dst_cur, src_cur;
  logic        last_byte;
  logic        spec_hit;
  logic [7:0]  spec_val;

  assign dst_cur   = upd_q + {7'd0, cnt_q};
  assign src_cur   = src_q + {7'd0, cnt_q};
  assign last_byte = (cnt_q == len_q - 9'd1);

  // Registers with side effects live in flops; most others come from the register RAM.
  always_comb begin
    spec_hit = sel_q inside {REG_UPD_HI, REG_UPD_LO, REG_BLK_MODE, REG_WORD_CNT,
                             REG_SRC_HI, REG_SRC_LO};
    case (sel_q)
      REG_UPD_HI:   spec_val = upd_q[15:8];
      REG_UPD_LO:   spec_val = upd_q[7:0];
      REG_BLK_MODE: spec_val = r24_q;
      REG_WORD_CNT: spec_val = r30_q;
      REG_SRC_HI:   spec_val = src_q[15:8];
      REG_SRC_LO:   spec_val = src_q[7:0];
      default:      spec_val = 8'h00;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    upd_d       = upd_q;
    src_d       = src_q;
    r24_d       = r24_q;
    r28_d       = r28_q;
    r30_d       = r30_q;
    r31_d       = r31_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    valid_d     = valid_q;
    out_valid_d = 1'b0;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    vram_we     = 1'b0;
    vram_waddr  = mask_addr(dst_cur, ram_64k_i);
    vram_wdata  = r31_q;
    vram_raddr  = mask_addr(src_cur, ram_64k_i);
    reg_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (cur_q.kind)
          KIND_STATUS: begin
            out_valid_d = 1'b1;
            out_data_d  = (cur_q.vblank ? 8'hA0 : 8'h80) | {5'd0, chip_rev_i};
          end
          KIND_SELECT: begin
            sel_d = cur_q.data[REG_AW-1:0];
          end
          KIND_REG_RD: begin
            if (sel_q == REG_DATA) begin
              vram_raddr = mask_addr(upd_q, ram_64k_i);
              upd_d      = ram_64k_i ? upd_q + 16'd1
                                     : {2'b00, upd_q[13:0] + 14'd1};
              state_d    = ST_VRAM_OUT;
            end else if (sel_q == REG_RAM_CFG) begin
              out_valid_d = 1'b1;
              out_data_d  = r28_q | (ram_64k_i ? 8'h1f : 8'h0f);
            end else if ({1'b0, sel_q} < RegCountV) begin
              if (spec_hit) begin
                out_valid_d = 1'b1;
                out_data_d  = spec_val | unused_bits(sel_q);
              end else begin
                state_d = ST_REG_OUT;
              end
            end else begin
              out_valid_d = 1'b1;
              out_data_d  = 8'hff;
            end
          end
          KIND_REG_WR: begin
            reg_we         = 1'b1;
            valid_d[sel_q] = 1'b1;
            case (sel_q)
              REG_UPD_HI:   upd_d[15:8] = cur_q.data;
              REG_UPD_LO:   upd_d[7:0]  = cur_q.data;
              REG_BLK_MODE: r24_d       = cur_q.data;
              REG_RAM_CFG:  r28_d       = cur_q.data;
              REG_SRC_HI:   src_d[15:8] = cur_q.data;
              REG_SRC_LO:   src_d[7:0]  = cur_q.data;
              REG_DATA: begin
                r31_d      = cur_q.data;
                vram_we    = 1'b1;
                vram_waddr = mask_addr(upd_q, ram_64k_i);
                vram_wdata = cur_q.data;
                upd_d      = upd_q + 16'd1;
              end
              REG_WORD_CNT: begin
                r30_d   = cur_q.data;
                cnt_d   = 9'd0;
                len_d   = (cur_q.data == 8'd0) ? 9'd256 : {1'b0, cur_q.data};
                state_d = r24_q[7] ? ST_BLK_RD : ST_FILL;
              end
              default: ;
            endcase
          end
          KIND_RAM_RD: begin
            vram_raddr = mask_addr(cur_q.addr, ram_64k_i);
            state_d    = ST_VRAM_OUT;
          end
          KIND_RAM_WR: begin
            vram_we    = 1'b1;
            vram_waddr = mask_addr(cur_q.addr, ram_64k_i);
            vram_wdata = cur_q.data;
          end
          default: ;
        endcase
      end
      ST_REG_OUT: begin
        out_valid_d = 1'b1;
        out_data_d  = (valid_q[sel_q] ? reg_rdata : 8'h00) | unused_bits(sel_q);
        state_d     = ST_IDLE;
      end
      ST_VRAM_OUT: begin
        out_valid_d = 1'b1;
        out_data_d  = vram_rdata;
        state_d     = ST_IDLE;
      end
      ST_FILL: begin
        vram_we = 1'b1;
        if (last_byte) begin
          upd_d   = upd_q + {7'd0, len_q};
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 9'd1;
        end
      end
      ST_BLK_RD: begin
        state_d = ST_BLK_WR;
      end
      ST_BLK_WR: begin
        // The last byte read is the one at the final source address, which the
        // data register keeps after the copy.
        vram_we    = 1'b1;
        vram_wdata = vram_rdata;
        r31_d      = vram_rdata;
        if (last_byte) begin
          upd_d   = upd_q + {7'd0, len_q};
          src_d   = src_q + {7'd0, len_q};
          state_d = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + 9'd1;
          state_d = ST_BLK_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
    cnt_q      <= cnt_d;
    len_q      <= len_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= '0;
      upd_q       <= '0;
      src_q       <= '0;
      r24_q       <= '0;
      r28_q       <= '0;
      r30_q       <= '0;
      r31_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      upd_q       <= upd_d;
      src_q       <= src_d;
      r24_q       <= r24_d;
      r28_q       <= r28_d;
      r30_q       <= r30_d;
      r31_q       <= r31_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  vdc_ram #(
    .Width(8),
    .Depth(VRAM_DEPTH)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  vdc_ram #(
    .Width(8),
    .Depth(REG_DEPTH)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (sel_q),
    .wdata_i (cur_q.data),
    .raddr_i (sel_q),
    .rdata_o (reg_rdata)
  );

  assign read_valid_o = out_valid_q;
  assign read_data_o  = out_data_q;

endmodule

[dv/tb.sv]
// Self-checking testbench for the indirect register port of the video controller.
// Drives port and direct RAM transactions, predicts every read byte and compares.
// Depends on vdc_pkg and video_controller_indirect_register_port.
`timescale 1ns / 1ps

module tb;
  import vdc_pkg::*;

  localparam int DRAIN_CYCLES = 2000;
  localparam int IDLE_LIMIT   = 20000;
  localparam int PHASE_ITEMS  = 150;
  localparam int RUN_SLOTS    = 16;
  localparam int REPORT_CAP   = 100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        vblank;
  } access_t;

  typedef struct {
    access_t    acc;
    bit         typed;
    logic [7:0] want;
  } row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic [1:0]            cmd_i       = CMD_PORT_RD;
  logic [15:0]           addr_i      = '0;
  logic [7:0]            data_i      = '0;
  logic                  in_vblank_i = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_RAM_64K;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  busy_o;
  logic                  read_valid_o;
  logic [7:0]            read_data_o;

  video_controller_indirect_register_port u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .addr_i       (addr_i),
    .data_i       (data_i),
    .in_vblank_i  (in_vblank_i),
    .read_valid_o (read_valid_o),
    .read_data_o  (read_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block's state.
  logic [7:0] regs [64];
  logic [5:0] reg_sel;
  logic [7:0] vram [65536];
  bit         vram_ok [65536];
  bit         mode64;
  logic [2:0] chip_rev;

  logic [7:0] awaited_bytes [$];
  access_t    queued_accesses [$];
  row_t       directed_rows [$];
  logic [7:0] oldest_byte;
  int         mismatches  = 0;
  int         idle_cycles = 0;
  int         calm_left   = 0;

  // Recently written RAM runs, used to aim reads and copies at defined bytes.
  logic [15:0] run_start [RUN_SLOTS];
  int          run_len [RUN_SLOTS];
  int          run_next = 0;
  int          run_cnt  = 0;

  bit         phase_64k [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [2:0] phase_rev [6] = '{3'd0, 3'd7, 3'd7, 3'd0, 3'd3, 3'd5};

  function automatic logic [7:0] spare_bits(logic [5:0] r);
    case (r)
      6'd8:                                return 8'hFC;
      6'd10:                               return 8'h80;
      6'd36:                               return 8'hF0;
      6'd37:                               return 8'h3F;
      6'd5, 6'd9, 6'd11, 6'd23, 6'd29:     return 8'hE0;
      default:                             return 8'h00;
    endcase
  endfunction

  function automatic logic [15:0] vram_idx(logic [15:0] a);
    return mode64 ? a : (a & 16'h3FFF);
  endfunction

  function automatic logic [15:0] reg_pair(logic [5:0] hi);
    return {regs[hi], regs[hi + 6'd1]};
  endfunction

  task automatic set_pair(logic [5:0] hi, logic [15:0] v);
    regs[hi]        = v[15:8];
    regs[hi + 6'd1] = v[7:0];
  endtask

  task automatic vram_store(logic [15:0] a, logic [7:0] v);
    logic [15:0] i;
    i          = vram_idx(a);
    vram[i]    = v;
    vram_ok[i] = 1'b1;
  endtask

  task automatic run_block();
    int          n;
    logic [15:0] dst;
    logic [15:0] src;
    n   = (regs[REG_WORD_CNT] == 8'd0) ? 256 : regs[REG_WORD_CNT];
    dst = reg_pair(REG_UPD_HI);
    if (regs[REG_BLK_MODE][7]) begin
      src = reg_pair(REG_SRC_HI);
      for (int i = 0; i < n; i++)
        vram_store(dst + 16'(i), vram[vram_idx(src + 16'(i))]);
      src            = src + 16'(n);
      regs[REG_DATA] = vram[vram_idx(src - 16'd1)];
      set_pair(REG_SRC_HI, src);
    end else begin
      for (int i = 0; i < n; i++)
        vram_store(dst + 16'(i), regs[REG_DATA]);
    end
    set_pair(REG_UPD_HI, dst + 16'(n));
  endtask

  // Applies one accepted transaction to the shadow state; returns the byte read, if any.
  task automatic apply_access(input access_t a, output bit gives, output logic [7:0] rd);
    logic [15:0] p;
    gives = 1'b0;
    rd    = 8'h00;
    case (a.cmd)
      CMD_PORT_RD: begin
        gives = 1'b1;
        if (!a.addr[0]) begin
          rd = (a.vblank ? 8'hA0 : 8'h80) | {5'b0, chip_rev};
        end else if (reg_sel == REG_DATA) begin
          p  = reg_pair(REG_UPD_HI);
          rd = vram[vram_idx(p)];
          set_pair(REG_UPD_HI, (p + 16'd1) & (mode64 ? 16'hFFFF : 16'h3FFF));
        end else if (reg_sel == REG_RAM_CFG) begin
          rd = regs[REG_RAM_CFG] | (mode64 ? 8'h1F : 8'h0F);
        end else if (reg_sel < REG_COUNT) begin
          rd = regs[reg_sel] | spare_bits(reg_sel);
        end else begin
          rd = 8'hFF;
        end
      end
      CMD_PORT_WR: begin
        if (!a.addr[0]) begin
          reg_sel = a.data[5:0];
        end else begin
          regs[reg_sel] = a.data;
          if (reg_sel == REG_WORD_CNT) begin
            run_block();
          end else if (reg_sel == REG_DATA) begin
            p = reg_pair(REG_UPD_HI);
            vram_store(p, a.data);
            set_pair(REG_UPD_HI, p + 16'd1);
          end
        end
      end
      CMD_RAM_RD: begin
        gives = 1'b1;
        rd    = vram[vram_idx(a.addr)];
      end
      default: vram_store(a.addr, a.data);
    endcase
  endtask

  function automatic logic [15:0] port_addr(bit p);
    return {15'($urandom), p};
  endfunction

  function automatic access_t acc(logic [1:0] c, logic [15:0] a, logic [7:0] d, logic vb);
    access_t r;
    r.cmd    = c;
    r.addr   = a;
    r.data   = d;
    r.vblank = vb;
    return r;
  endfunction

  function automatic row_t row(logic [1:0] c, logic [15:0] a, logic [7:0] d, logic vb,
                               bit typed, logic [7:0] want);
    row_t r;
    r.acc   = acc(c, a, d, vb);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Turns any transaction that would read never-written RAM into a status read,
  // and keeps most long block operations short.
  function automatic access_t legalize(access_t a);
    access_t     r;
    bit          ok;
    int          n;
    logic [15:0] src;
    r  = a;
    ok = 1'b1;
    if (a.cmd == CMD_RAM_RD) begin
      ok = vram_ok[vram_idx(a.addr)];
    end else if (a.cmd == CMD_PORT_RD && a.addr[0] && reg_sel == REG_DATA) begin
      ok = vram_ok[vram_idx(reg_pair(REG_UPD_HI))];
    end else if (a.cmd == CMD_PORT_WR && a.addr[0] && reg_sel == REG_WORD_CNT) begin
      n = (a.data == 8'd0) ? 256 : a.data;
      if (n > 64 && $urandom_range(0, 3) != 0) begin
        r.data = 8'($urandom_range(1, 16));
        n      = r.data;
      end
      if (regs[REG_BLK_MODE][7]) begin
        src = reg_pair(REG_SRC_HI);
        for (int i = 0; i < n; i++)
          if (!vram_ok[vram_idx(src + 16'(i))]) ok = 1'b0;
      end
    end
    if (!ok) begin
      r.cmd  = CMD_PORT_RD;
      r.addr = port_addr(1'b0);
    end
    return r;
  endfunction

  function automatic int block_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 64);
    return ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(128, 255);
  endfunction

  task automatic note_run(logic [15:0] s, int n);
    run_start[run_next] = s;
    run_len[run_next]   = n;
    run_next            = (run_next + 1) % RUN_SLOTS;
    if (run_cnt < RUN_SLOTS) run_cnt++;
  endtask

  task automatic queue_select(logic [5:0] r);
    queued_accesses.push_back(acc(CMD_PORT_WR, port_addr(1'b0), {2'($urandom), r},
                                  1'($urandom)));
  endtask

  task automatic queue_reg_write(logic [5:0] r, logic [7:0] v);
    queue_select(r);
    queued_accesses.push_back(acc(CMD_PORT_WR, port_addr(1'b1), v, 1'($urandom)));
  endtask

  task automatic queue_pointer(logic [5:0] hi, logic [15:0] p);
    queue_reg_write(hi, p[15:8]);
    queue_reg_write(hi + 6'd1, p[7:0]);
  endtask

  task automatic queue_port1_read();
    queued_accesses.push_back(acc(CMD_PORT_RD, port_addr(1'b1), 8'($urandom), 1'($urandom)));
  endtask

  task automatic build_sequence();
    int          n;
    int          k;
    int          len;
    logic [15:0] p;
    logic [15:0] q;
    logic [5:0]  r;
    case ($urandom_range(0, 9))
      0, 1: begin
        p = 16'($urandom);
        n = $urandom_range(1, 8);
        queue_pointer(REG_UPD_HI, p);
        queue_select(REG_DATA);
        repeat (n)
          queued_accesses.push_back(acc(CMD_PORT_WR, port_addr(1'b1), 8'($urandom),
                                        1'($urandom)));
        note_run(p, n);
      end
      2: begin
        if (run_cnt > 0) begin
          k = $urandom_range(0, run_cnt - 1);
          n = $urandom_range(1, (run_len[k] < 8) ? run_len[k] : 8);
          queue_pointer(REG_UPD_HI, run_start[k]);
          queue_select(REG_DATA);
          repeat (n) queue_port1_read();
        end
      end
      3: begin
        p   = 16'($urandom);
        len = block_len();
        queue_reg_write(REG_BLK_MODE, {1'b0, 7'($urandom)});
        queue_pointer(REG_UPD_HI, p);
        queue_reg_write(REG_DATA, 8'($urandom));
        queue_reg_write(REG_WORD_CNT, 8'(len));
        note_run(p, len + 1);
      end
      4: begin
        if (run_cnt > 0) begin
          k   = $urandom_range(0, run_cnt - 1);
          len = block_len();
          if (len > run_len[k]) len = run_len[k];
          q = run_start[k];
          p = ($urandom_range(0, 3) == 0) ? q + 16'($urandom_range(1, 4)) : 16'($urandom);
          queue_pointer(REG_SRC_HI, q);
          queue_reg_write(REG_BLK_MODE, {1'b1, 7'($urandom)});
          queue_pointer(REG_UPD_HI, p);
          queue_reg_write(REG_WORD_CNT, 8'(len));
          note_run(p, len);
          queue_pointer(REG_UPD_HI, p);
          queue_select(REG_DATA);
          repeat ((len < 4) ? len : 4) queue_port1_read();
        end
      end
      5: begin
        r = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, REG_COUNT - 1));
        queue_reg_write(r, 8'($urandom));
        queue_port1_read();
        queued_accesses.push_back(acc(CMD_PORT_RD, port_addr(1'b0), 8'($urandom),
                                      1'($urandom)));
      end
      6: begin
        p = 16'($urandom);
        queued_accesses.push_back(acc(CMD_RAM_WR, p, 8'($urandom), 1'($urandom)));
        queued_accesses.push_back(acc(CMD_RAM_RD, p, 8'($urandom), 1'($urandom)));
        note_run(p, 1);
      end
      7: begin
        case ($urandom_range(0, 5))
          0:       r = REG_UPD_HI;
          1:       r = REG_UPD_LO;
          2:       r = REG_SRC_HI;
          3:       r = REG_SRC_LO;
          4:       r = REG_RAM_CFG;
          default: r = REG_DATA;
        endcase
        queue_select(r);
        queue_port1_read();
      end
      default: begin
        repeat ($urandom_range(1, 4))
          queued_accesses.push_back(acc(2'($urandom), 16'($urandom), 8'($urandom),
                                        1'($urandom)));
      end
    endcase
  endtask

  // Presents one transaction, waits for it to be taken and records what it must return.
  task automatic drive_access(access_t a, bit typed, logic [7:0] want);
    bit         gives;
    logic [7:0] rd;
    start_i     <= 1'b1;
    cmd_i       <= a.cmd;
    addr_i      <= a.addr;
    data_i      <= a.data;
    in_vblank_i <= a.vblank;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_access(a, gives, rd);
    if (gives) awaited_bytes.push_back(typed ? want : rd);
  endtask

  // Mostly no gap or a short one, a few long ones, and stretches with none at all.
  task automatic pause_sender();
    int g;
    int r;
    g = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      calm_left = 30;
    end else begin
      r = $urandom_range(0, 99);
      if (r >= 90)      g = $urandom_range(10, 40);
      else if (r >= 55) g = $urandom_range(1, 3);
    end
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic run_random(int quota);
    int      issued;
    access_t a;
    issued = 0;
    while (issued < quota) begin
      if (queued_accesses.size() == 0) begin
        build_sequence();
      end else begin
        a = legalize(queued_accesses.pop_front());
        drive_access(a, 1'b0, 8'h00);
        issued++;
        pause_sender();
      end
    end
  endtask

  // Block writes produce no result, so wait out the longest block operations too:
  // one running and two queued copies of 256 bytes.
  task automatic settle_block();
    start_i <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(bit m64, logic [2:0] rev);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RAM_64K;
    cfg_wdata_i <= {2'b00, m64};
    @(posedge clk_i);
    mode64      = m64;
    cfg_idx_i   <= CFG_CHIP_REV;
    cfg_wdata_i <= rev;
    @(posedge clk_i);
    chip_rev    = rev;
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && read_valid_o) begin
      if (awaited_bytes.size() == 0) begin
        if (mismatches < REPORT_CAP)
          $error("read_data: transaction with nothing expected, actual %02h", read_data_o);
        mismatches++;
      end else begin
        oldest_byte = awaited_bytes.pop_front();
        if (oldest_byte !== read_data_o) begin
          if (mismatches < REPORT_CAP)
            $error("read_data: expected %02h, actual %02h", oldest_byte, read_data_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || read_valid_o || cfg_we_i) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 64; i++) regs[i] = 8'h00;
    reg_sel  = '0;
    mode64   = 1'b1;
    chip_rev = 3'd2;

    // Status, register select, unused bits, RAM extremes, update address wrap,
    // and a fill with a word count of zero (256 bytes).
    directed_rows.push_back(row(CMD_PORT_RD, 16'h0000, 8'h00, 1'b0, 1, 8'h82));
    directed_rows.push_back(row(CMD_PORT_RD, 16'hFFFE, 8'hFF, 1'b1, 1, 8'hA2));
    directed_rows.push_back(row(CMD_PORT_RD, 16'h0001, 8'h00, 1'b0, 1, 8'h00));
    // Select register 5 with the two top bits set; they must be dropped.
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0000, 8'hC5, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_RD, 16'hFFFF, 8'h00, 1'b1, 1, 8'hE0));
    directed_rows.push_back(row(CMD_PORT_WR, 16'hFFFE, 8'hFF, 1'b1, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0001, 8'hAB, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_RD, 16'h0001, 8'h00, 1'b0, 1, 8'hFF));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0000, {2'b00, REG_RAM_CFG}, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_RD, 16'h0001, 8'h00, 1'b0, 1, 8'h1F));
    directed_rows.push_back(row(CMD_RAM_WR,  16'hFFFF, 8'hFF, 1'b1, 0, 8'h00));
    directed_rows.push_back(row(CMD_RAM_RD,  16'hFFFF, 8'h00, 1'b0, 1, 8'hFF));
    directed_rows.push_back(row(CMD_RAM_WR,  16'h0000, 8'h00, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0000, {2'b00, REG_UPD_HI}, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0001, 8'hFF, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0000, {2'b00, REG_UPD_LO}, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0001, 8'hFF, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0000, {2'b00, REG_DATA}, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0001, 8'h5A, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_RD, 16'h0001, 8'h00, 1'b0, 1, 8'h00));
    directed_rows.push_back(row(CMD_RAM_RD,  16'hFFFF, 8'h00, 1'b1, 1, 8'h5A));
    directed_rows.push_back(row(CMD_PORT_WR, 16'h0000, {2'b00, REG_WORD_CNT}, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_WR, 16'hFFFF, 8'h00, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_RAM_RD,  16'h0100, 8'h00, 1'b0, 0, 8'h00));
    directed_rows.push_back(row(CMD_PORT_RD, 16'h0001, 8'h00, 1'b0, 0, 8'h00));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      drive_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);
      pause_sender();
    end
    note_run(16'h0001, 256);
    run_random(PHASE_ITEMS);

    foreach (phase_64k[i]) begin
      settle_block();
      write_config(phase_64k[i], phase_rev[i]);
      run_random(PHASE_ITEMS);
    end

    settle_block();
    if (mismatches == 0 && awaited_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
design/vdc_pkg.sv
design/vdc_ram.sv
design/vdc_front.sv
design/vdc_back.sv
design/video_controller_indirect_register_port.sv
dv/tb.sv
